// File: rtl/core/weekday_from_reference_date_top_defines.svh
// assertion macros shared by the weekday-from-reference-date rtl
// no dependencies; included inside module bodies after the package import
`ifndef WEEKDAY_FROM_REFERENCE_DATE_TOP_DEFINES_SVH
`define WEEKDAY_FROM_REFERENCE_DATE_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define WDFRD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wdfrd assertion failed");

// next-cycle implication, disabled while reset is asserted
`define WDFRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wdfrd assertion failed");

`endif

// File: rtl/core/wdfrd_pkg.sv
// package for the weekday-from-reference-date block
// holds controller states, command/status structs, calendar constants and month length
`default_nettype none

package wdfrd_pkg;

    localparam int PACK_W = 28;

    localparam logic [13:0] YEAR_MIN = 14'd1000;
    localparam logic [13:0] YEAR_MAX = 14'd9999;
    localparam logic [6:0]  MONTH_MIN = 7'd1;
    localparam logic [6:0]  DAY_MIN = 7'd1;
    localparam logic [2:0]  WEEKDAY_MAX = 3'd6;

    localparam logic [6:0] MON_JAN = 7'd1;
    localparam logic [6:0] MON_FEB = 7'd2;
    localparam logic [6:0] MON_APR = 7'd4;
    localparam logic [6:0] MON_JUN = 7'd6;
    localparam logic [6:0] MON_SEP = 7'd9;
    localparam logic [6:0] MON_NOV = 7'd11;
    localparam logic [6:0] MON_DEC = 7'd12;

    localparam logic [4:0] LEN_31 = 5'd31;
    localparam logic [4:0] LEN_30 = 5'd30;
    localparam logic [4:0] LEN_29 = 5'd29;
    localparam logic [4:0] LEN_28 = 5'd28;

    // packed date = year * 10000 + month * 100 + day
    localparam logic [PACK_W-1:0] PACK_YEAR  = 28'd10000;
    localparam logic [PACK_W-1:0] PACK_MONTH = 28'd100;
    // month rollover adds 100 + 1 - day, year rollover goes from 1231 to 10101
    localparam logic [PACK_W-1:0] PACK_MONTH_STEP = 28'd101;
    localparam logic [PACK_W-1:0] PACK_YEAR_STEP  = 28'd8870;

    // year / 100 as (year * 5243) >> 19, exact for 14-bit years
    localparam logic [26:0] YEAR_RECIP  = 27'd5243;
    localparam int          RECIP_SHIFT = 19;
    localparam logic [13:0] CENTURY     = 14'd100;
    localparam logic [6:0]  CENTURY_LAST = 7'd99;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SPLIT,
        ST_CHECK,
        ST_RUN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic load;
        logic split;
        logic check;
        logic step;
    } t_dp_cmd;

    typedef struct packed {
        logic ref_ok;
        logic below;
    } t_dp_sts;

    function automatic logic [4:0] month_len(input logic [6:0] month, input logic leap);
        logic [4:0] len;
        case (month)
            MON_FEB: len = leap ? LEN_29 : LEN_28;
            MON_APR, MON_JUN, MON_SEP, MON_NOV: len = LEN_30;
            default: len = LEN_31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/weekday_from_reference_date_top.sv
// top level of the weekday-from-reference-date block
// depends on wdfrd_pkg, wdfrd_ctrl and wdfrd_dp
//
// usage: drive the reference date, its weekday and the target date, and raise start.
// a transaction is accepted at a rising edge with start high and busy low; the fields
// are sampled at that edge. busy stays high until the result has been shown.
// the result (o_weekday, o_valid_res) is shown for exactly one cycle with o_done high;
// the receiver cannot stall it and must take it in that cycle.
// an invalid reference gives o_valid_res = 0 and o_weekday = 0; a valid reference is
// stepped n days before o_done, n = days stepped from reference to target.
// the day stepper advances one calendar day per cycle; n is 0 when the target is at
// or before the reference and about 3.3 million for a reference in year 1000 and a
// target near year 9999.
// a new transaction can be accepted in the cycle after o_done.
// reset (synchronous, active low) returns the controller to idle; any transaction in
// flight is dropped without a result.
`default_nettype none

module weekday_from_reference_date_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [13:0] i_ref_year,
    input  logic [6:0]  i_ref_month,
    input  logic [6:0]  i_ref_day,
    input  logic [2:0]  i_ref_weekday,
    input  logic [13:0] i_target_year,
    input  logic [6:0]  i_target_month,
    input  logic [6:0]  i_target_day,
    output logic        o_done,
    output logic [2:0]  o_weekday,
    output logic        o_valid_res
);
    import wdfrd_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    wdfrd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    wdfrd_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_ref_year     (i_ref_year),
        .i_ref_month    (i_ref_month),
        .i_ref_day      (i_ref_day),
        .i_ref_weekday  (i_ref_weekday),
        .i_target_year  (i_target_year),
        .i_target_month (i_target_month),
        .i_target_day   (i_target_day),
        .o_sts          (w_sts),
        .o_weekday      (o_weekday),
        .o_valid_res    (o_valid_res)
    );

endmodule

`default_nettype wire

// File: rtl/core/wdfrd_dp.sv
// datapath: captures the dates, checks the reference and steps it one day per cycle
// depends on wdfrd_pkg and weekday_from_reference_date_top_defines.svh
`default_nettype none

module wdfrd_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  wdfrd_pkg::t_dp_cmd i_cmd,
    input  logic [13:0]        i_ref_year,
    input  logic [6:0]         i_ref_month,
    input  logic [6:0]         i_ref_day,
    input  logic [2:0]         i_ref_weekday,
    input  logic [13:0]        i_target_year,
    input  logic [6:0]         i_target_month,
    input  logic [6:0]         i_target_day,
    output wdfrd_pkg::t_dp_sts o_sts,
    output logic [2:0]         o_weekday,
    output logic               o_valid_res
);
    import wdfrd_pkg::*;
    `include "weekday_from_reference_date_top_defines.svh"

    logic [13:0]       r_ry;
    logic [6:0]        r_month;
    logic [6:0]        r_day;
    logic [2:0]        r_wd;
    logic              r_valid;
    logic [13:0]       r_ty;
    logic [6:0]        r_tm;
    logic [6:0]        r_td;
    logic [26:0]       r_qprod;
    logic [PACK_W-1:0] r_pack;
    logic [PACK_W-1:0] r_tpack;
    // current year kept only as its residues
    logic [1:0]        r_ymod4;
    logic [6:0]        r_ymod100;
    logic [1:0]        r_cmod4;

    logic [7:0]        w_cent;
    logic [13:0]       w_cent_prod;
    logic              w_leap;
    logic [4:0]        w_mlen;
    logic              w_ref_ok;

    assign w_cent      = r_qprod[RECIP_SHIFT+7:RECIP_SHIFT];
    assign w_cent_prod = 14'({6'd0, w_cent} * CENTURY);
    assign w_leap      = (r_ymod4 == 2'd0) && ((r_ymod100 != 7'd0) || (r_cmod4 == 2'd0));
    assign w_mlen      = month_len(r_month, w_leap);
    assign w_ref_ok    = (r_ry >= YEAR_MIN) && (r_ry <= YEAR_MAX)
                      && (r_month >= MONTH_MIN) && (r_month <= MON_DEC)
                      && (r_day >= DAY_MIN) && (r_day <= {2'd0, w_mlen})
                      && (r_wd <= WEEKDAY_MAX);

    assign o_sts.ref_ok = w_ref_ok;
    assign o_sts.below  = r_pack < r_tpack;
    assign o_weekday    = r_wd;
    assign o_valid_res  = r_valid;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_ry    <= i_ref_year;
            r_month <= i_ref_month;
            r_day   <= i_ref_day;
            r_wd    <= i_ref_weekday;
            r_ty    <= i_target_year;
            r_tm    <= i_target_month;
            r_td    <= i_target_day;
        end
        if (i_cmd.load) begin
            r_qprod <= {13'd0, r_ry} * YEAR_RECIP;
            r_pack  <= PACK_W'(r_ry) * PACK_YEAR + PACK_W'(r_month) * PACK_MONTH
                     + PACK_W'(r_day);
            r_tpack <= PACK_W'(r_ty) * PACK_YEAR + PACK_W'(r_tm) * PACK_MONTH
                     + PACK_W'(r_td);
        end
        if (i_cmd.split) begin
            r_ymod4   <= r_ry[1:0];
            r_ymod100 <= 7'(r_ry - w_cent_prod);
            r_cmod4   <= w_cent[1:0];
        end
        if (i_cmd.check) begin
            r_valid <= w_ref_ok;
            if (!w_ref_ok) begin
                r_wd <= 3'd0;
            end
        end
        if (i_cmd.step) begin
            r_wd <= (r_wd == WEEKDAY_MAX) ? 3'd0 : r_wd + 3'd1;
            if (r_day < {2'd0, w_mlen}) begin
                r_day  <= r_day + 7'd1;
                r_pack <= r_pack + PACK_W'(1);
            end else if (r_month < MON_DEC) begin
                r_day   <= DAY_MIN;
                r_month <= r_month + 7'd1;
                r_pack  <= r_pack + PACK_MONTH_STEP - PACK_W'(r_day);
            end else begin
                // new year: roll the residues forward
                r_day   <= DAY_MIN;
                r_month <= MON_JAN;
                r_pack  <= r_pack + PACK_YEAR_STEP;
                r_ymod4 <= r_ymod4 + 2'd1;
                if (r_ymod100 == CENTURY_LAST) begin
                    r_ymod100 <= 7'd0;
                    r_cmod4   <= r_cmod4 + 2'd1;
                end else begin
                    r_ymod100 <= r_ymod100 + 7'd1;
                end
            end
        end
    end

    `WDFRD_ASSERT_NEXT(a_step_advances, i_clk, i_rst_n, i_cmd.step, r_pack > $past(r_pack))
    `WDFRD_ASSERT_NEXT(a_step_date_ok, i_clk, i_rst_n, i_cmd.step,
                       r_day >= DAY_MIN && r_day <= 7'd31 && r_month <= MON_DEC)
    `WDFRD_ASSERT_NEXT(a_invalid_zero, i_clk, i_rst_n, i_cmd.check,
                       r_valid || r_wd == 3'd0)
    `WDFRD_ASSERT_NEXT(a_step_weekday, i_clk, i_rst_n, i_cmd.step, r_wd <= WEEKDAY_MAX)

endmodule

`default_nettype wire

// File: rtl/core/wdfrd_ctrl.sv
// controller state machine: sequences capture, reference check and day stepping
// depends on wdfrd_pkg and weekday_from_reference_date_top_defines.svh
`default_nettype none

module wdfrd_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  wdfrd_pkg::t_dp_sts i_sts,
    output wdfrd_pkg::t_dp_cmd o_cmd,
    output logic               o_busy,
    output logic               o_done
);
    import wdfrd_pkg::*;
    `include "weekday_from_reference_date_top_defines.svh"

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        o_done  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_LOAD;
                end
            end
            ST_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = ST_SPLIT;
            end
            ST_SPLIT: begin
                o_cmd.split = 1'b1;
                n_state     = ST_CHECK;
            end
            ST_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = i_sts.ref_ok ? ST_RUN : ST_DONE;
            end
            ST_RUN: begin
                if (i_sts.below) begin
                    o_cmd.step = 1'b1;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                o_done  = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    `WDFRD_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy)
    `WDFRD_ASSERT_NEXT(a_accept_no_done, i_clk, i_rst_n, i_start && !o_busy, !o_done)
    `WDFRD_ASSERT_NEXT(a_done_frees, i_clk, i_rst_n, o_done, !o_busy && !o_done)
    `WDFRD_ASSERT_NOW(a_step_in_run, i_clk, i_rst_n, o_cmd.step, o_busy && !o_done)

endmodule

`default_nettype wire
